// ----- rtl/ps2mt_pkg.sv -----
// Shared constants for the PS/2 mouse packet tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ps2mt_pkg;

    // coordinate width default and range of the configuration registers
    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_W         = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int BTN_W          = 3;
    localparam int DELTA_W        = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd768;

    // pointer position after reset (saturated to the coordinate range)
    localparam int RESET_X = 512;
    localparam int RESET_Y = 384;

    // byte 0 of a packet always has this bit set
    localparam int SYNC_BIT = 3;

    // packet byte position
    localparam logic [1:0] SLOT_HEAD  = 2'd0;
    localparam logic [1:0] SLOT_DX    = 2'd1;
    localparam logic [1:0] SLOT_DY    = 2'd2;

endpackage

// ----- rtl/ps2mt_clamp.sv -----
// One axis of the pointer: adds a signed step and clamps to 0 .. size-1.
// Depends on ps2mt_pkg.
`timescale 1ns / 1ps

module ps2mt_clamp
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]     i_pos,
    input  logic signed [DELTA_W-1:0] i_delta,
    input  logic [SIZE_W-1:0]         i_size,
    output logic [COORD_BITS-1:0]     o_pos
);

    localparam logic [31:0] LIMIT = 32'd1 << COORD_BITS;

    logic [31:0]                size_wide;
    logic [31:0]                eff_wide;
    logic [COORD_BITS:0]        eff;
    logic [COORD_BITS:0]        eff_m1;
    logic signed [COORD_BITS+1:0] sum;

    always_comb begin
        size_wide = 32'(i_size);
        // zero counts as one, anything past the coordinate range is cut to it
        if (size_wide == 32'd0) begin
            eff_wide = 32'd1;
        end else if (size_wide > LIMIT) begin
            eff_wide = LIMIT;
        end else begin
            eff_wide = size_wide;
        end
        eff    = eff_wide[COORD_BITS:0];
        eff_m1 = eff - 1'b1;

        sum = $signed({2'b00, i_pos}) + (COORD_BITS+2)'(i_delta);

        if (sum[COORD_BITS+1]) begin
            o_pos = '0;
        end else if (sum[COORD_BITS:0] >= eff) begin
            o_pos = eff_m1[COORD_BITS-1:0];
        end else begin
            o_pos = sum[COORD_BITS-1:0];
        end
    end

endmodule

// ----- rtl/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: packet framing, position state,
// result register with skid stage. Depends on ps2mt_pkg and ps2mt_clamp.
`timescale 1ns / 1ps

// Usage
//   s_axis: one raw mouse byte per request (tdata[7:0]). A packet starts only
//   on a byte with bit 3 set; other bytes in that position are dropped.
//   m_axis: one request per completed 3-byte packet carrying the clamped
//   position and buttons.
//   Config: i_cfg_we/i_cfg_index/i_cfg_data write screen width (index 0) and
//   screen height (index 1); write only while the block is idle.
// Timing
//   One byte is taken every cycle while s_axis_tready is high. The whole packet
//   update (add, clamp) is done in the cycle the third byte is taken; the
//   result is registered in the result register, or in the skid entry on a stall.
//   A result register plus one skid entry sit on the output: when the
//   receiver stalls, one more packet can complete into the skid entry, after
//   which s_axis_tready drops until the skid entry drains.
// Reset
//   Synchronous, active low: width 1024, height 768, position (512, 384)
//   saturated to the coordinate range, packet framing back to the first
//   byte, both output entries empty.
module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    // byte stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    // packet results out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [((2*COORD_BITS+BTN_W+7)/8)*8-1:0] m_axis_tdata
        // pos_x, then pos_y, then button_bits, zero filled
);

    localparam int RES_W  = 2*COORD_BITS + BTN_W;
    localparam int DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int MASK   = (1 << COORD_BITS) - 1;
    localparam logic [COORD_BITS-1:0] RST_X =
        COORD_BITS'((RESET_X > MASK) ? MASK : RESET_X);
    localparam logic [COORD_BITS-1:0] RST_Y =
        COORD_BITS'((RESET_Y > MASK) ? MASK : RESET_Y);

    logic [SIZE_W-1:0]     r_width;
    logic [SIZE_W-1:0]     r_height;
    logic [1:0]            r_slot;
    logic [1:0]            n_slot;
    logic [7:0]            r_head;
    logic [7:0]            r_dx;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;

    logic                  r_out_valid;
    logic [RES_W-1:0]      r_out;
    logic                  r_skid_valid;
    logic [RES_W-1:0]      r_skid;

    logic                  in_fire;
    logic                  out_fire;
    logic                  res_valid;
    logic [RES_W-1:0]      res;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [COORD_BITS-1:0] nx;
    logic [COORD_BITS-1:0] ny;
    logic [BTN_W-1:0]      btn;

    assign s_axis_tready = ~r_skid_valid;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = r_out_valid & m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out);

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // X adds the signed step, Y subtracts it (screen Y grows downward)
    assign dx  = DELTA_W'($signed(r_dx));
    assign dy  = -DELTA_W'($signed(s_axis_tdata));
    assign btn = r_head[BTN_W-1:0];

    ps2mt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .i_pos   (r_x),
        .i_delta (dx),
        .i_size  (r_width),
        .o_pos   (nx)
    );

    ps2mt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .i_pos   (r_y),
        .i_delta (dy),
        .i_size  (r_height),
        .o_pos   (ny)
    );

    assign res_valid = in_fire && (r_slot == SLOT_DY);
    assign res       = {btn, ny, nx};

    always_comb begin
        n_slot = r_slot;
        if (in_fire) begin
            case (r_slot)
                SLOT_HEAD: n_slot = s_axis_tdata[SYNC_BIT] ? SLOT_DX : SLOT_HEAD;
                SLOT_DX:   n_slot = SLOT_DY;
                SLOT_DY:   n_slot = SLOT_HEAD;
                default:   n_slot = SLOT_HEAD;
            endcase
        end
    end

    // framing and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_HEAD;
            r_x    <= RST_X;
            r_y    <= RST_Y;
        end else begin
            r_slot <= n_slot;
            if (res_valid) begin
                r_x   <= nx;
                r_y   <= ny;
            end
        end
    end

    // held packet bytes
    always_ff @(posedge i_clk) begin
        if (in_fire && r_slot == SLOT_HEAD) begin
            r_head <= s_axis_tdata;
        end
        if (in_fire && r_slot == SLOT_DX) begin
            r_dx <= s_axis_tdata;
        end
    end

    // result register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    // checks
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("packet slot out of range");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> m_axis_tvalid)
        else $error("completed packet did not reach the output");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res_valid |=> (r_x == $past(r_x)) && (r_y == $past(r_y)))
        else $error("position moved without a completed packet");

endmodule
